>>> src/two_tone_alarm_generator_top_assert.svh
// Assertion macros for the two-tone alarm generator.
// Used by the port checker; needs nothing else.
`ifndef TWO_TONE_ALARM_GENERATOR_TOP_ASSERT_SVH
`define TWO_TONE_ALARM_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define TTAG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTAG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ttag_pkg.sv
// Shared types, codes and sine table function of the two-tone alarm generator.
// No dependencies.
package ttag_pkg;

   // operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   // segment codes on the result channel
   localparam logic [1:0] SEG_A    = 2'd0;
   localparam logic [1:0] SEG_B    = 2'd1;
   localparam logic [1:0] SEG_GAP  = 2'd2;
   localparam logic [1:0] SEG_IDLE = 2'd3;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_TONE_A_STEP   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TONE_B_STEP   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TONE_SAMPLES  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAP_SAMPLES   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDE     = 3'd4;

   // timing constants
   localparam int TONE_MS    = 180;
   localparam int GAP_MS     = 80;
   localparam int MS_PER_SEC = 1000;
   localparam logic [19:0] CYCLE_MS     = 20'd440;
   localparam logic [19:0] LIMIT_RESET  = 20'd60000;
   localparam logic [15:0] MIN_SEC      = 16'd5;
   localparam logic [15:0] MAX_SEC      = 16'd600;

   localparam logic [31:0] STEP_A_RESET = 32'd85704562;
   localparam logic [31:0] STEP_B_RESET = 32'd96222849;
   localparam logic [14:0] AMP_RESET    = 15'd12000;

   // hand-off queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] duration_sec;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               active;
      logic [1:0]         segment;
   } rsp_type;

   typedef struct packed {
      logic [31:0] tone_a_step;
      logic [31:0] tone_b_step;
      logic [15:0] tone_samples;
      logic [15:0] gap_samples;
      logic [14:0] amplitude;
   } cfg_type;

   // one classified transaction: top phase bits feed the sine lookup
   typedef struct packed {
      logic        active;
      logic [1:0]  segment;
      logic        tone;
      logic [15:0] phase_hi;
   } work_type;

   // sine table build, evaluated at elaboration only
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [8] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                              64'd72, 64'd110, 64'd156, 64'd210};

   function automatic logic [14:0] sine_entry(int unsigned k, int unsigned bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x    = (HALF_PI_Q30 * ((64'(k) << 1) + 64'd1)) >> (bits + 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int unsigned n = 1; n < 8; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum + 64'd16384) >> 15;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

endpackage

>>> src/two_tone_alarm_generator_top.sv
// Top level of the two-tone alarm generator: CSR bank and front/queue/back.
// Depends on ttag_pkg, ttag_front, ttag_queue and ttag_back.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_type  (operation, duration_sec)
//   rsp      out        rsp_valid/stall    rsp_type  (sample, active, segment)
//   csr      in         csr_valid/ready    csr_index, csr_wdata
//
// One transaction per clock sustained on req while req_stall is low; every req
// transaction gives exactly one rsp transaction, in order. At the earliest,
// rsp_valid rises once the work has passed the queue write on the accepting
// edge, the sine table read register and the multiply into the result register.
// Latency is set by the table read and the amplitude multiplier.
// Reset is synchronous; no clearing pass, the block takes work the cycle
// after reset drops. rsp_stall backs up the back end; req_stall rises only
// when the four-entry queue is full. csr writes always complete.
module two_tone_alarm_generator_top
   import ttag_pkg::*;
#(
   parameter int SAMPLE_RATE     = 44100,
   parameter int SINE_TABLE_BITS = 10
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   // segment lengths out of reset follow the sample rate
   localparam logic [15:0] TONE_RESET = 16'((SAMPLE_RATE * TONE_MS) / MS_PER_SEC);
   localparam logic [15:0] GAP_RESET  = 16'((SAMPLE_RATE * GAP_MS) / MS_PER_SEC);

   cfg_type  cfg_ff, cfg_in;
   logic     queue_full;
   logic     push_valid;
   work_type push_data;
   logic     pop_valid;
   logic     pop_ready;
   work_type pop_data;

   // CSR bank: every write is taken at once and registered; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TONE_A_STEP:  cfg_in.tone_a_step  = csr_wdata;
            REG_TONE_B_STEP:  cfg_in.tone_b_step  = csr_wdata;
            REG_TONE_SAMPLES: cfg_in.tone_samples = csr_wdata[15:0];
            REG_GAP_SAMPLES:  cfg_in.gap_samples  = csr_wdata[15:0];
            REG_AMPLITUDE:    cfg_in.amplitude    = csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tone_a_step  <= STEP_A_RESET;
         cfg_ff.tone_b_step  <= STEP_B_RESET;
         cfg_ff.tone_samples <= TONE_RESET;
         cfg_ff.gap_samples  <= GAP_RESET;
         cfg_ff.amplitude    <= AMP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: sequencer, phases, elapsed time
   ttag_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // decouples the sequencer from output back-pressure
   ttag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: sine lookup, scaling, sign, output register
   ttag_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .amplitude  (cfg_ff.amplitude),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

>>> src/ttag_front.sv
// Front end: accepts transactions and runs the alarm sequencer state.
// Depends on ttag_pkg; pushes classified work into ttag_queue.
module ttag_front
   import ttag_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  cfg_type  cfg,
   input  logic     queue_full,
   output logic     push_valid,
   output work_type push_data
);

   typedef enum logic [3:0] {
      ST_TONE_A = 4'b0001,
      ST_TONE_B = 4'b0010,
      ST_GAP    = 4'b0100,
      ST_IDLE   = 4'b1000
   } seg_state_type;

   function automatic logic [1:0] seg_code(seg_state_type s);
      logic [1:0] c;
      unique case (s)
         ST_TONE_A: c = SEG_A;
         ST_TONE_B: c = SEG_B;
         ST_GAP:    c = SEG_GAP;
         default:   c = SEG_IDLE;
      endcase
      return c;
   endfunction

   logic [31:0]   phase_a_ff, phase_a_in;
   logic [31:0]   phase_b_ff, phase_b_in;
   seg_state_type seg_ff, seg_in;
   logic [15:0]   count_ff, count_in;
   logic [19:0]   elapsed_ff, elapsed_in;
   logic [19:0]   limit_ff, limit_in;
   logic          running_ff, running_in;

   logic          accept;
   logic [9:0]    sec_clamped;
   logic [16:0]   next_count;
   logic [19:0]   elapsed_next;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;

   always_comb begin
      if (req_data.duration_sec < MIN_SEC) begin
         sec_clamped = MIN_SEC[9:0];
      end else if (req_data.duration_sec > MAX_SEC) begin
         sec_clamped = MAX_SEC[9:0];
      end else begin
         sec_clamped = req_data.duration_sec[9:0];
      end
   end

   assign next_count   = {1'b0, count_ff} + 17'd1;
   assign elapsed_next = elapsed_ff + CYCLE_MS;

   always_comb begin
      phase_a_in = phase_a_ff;
      phase_b_in = phase_b_ff;
      seg_in     = seg_ff;
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      limit_in   = limit_ff;
      running_in = running_ff;
      push_data  = '0;

      if (accept) begin
         if (req_data.operation == OP_START) begin
            limit_in   = 20'(sec_clamped) * 20'(MS_PER_SEC);
            phase_a_in = '0;
            phase_b_in = '0;
            elapsed_in = '0;
            count_in   = '0;
            seg_in     = ST_TONE_A;
            running_in = 1'b1;
         end else if (req_data.operation == OP_STOP) begin
            running_in = 1'b0;
            seg_in     = ST_IDLE;
            count_in   = '0;
         end

         push_data.active  = running_in;
         push_data.segment = running_in ? seg_code(seg_in) : SEG_IDLE;

         if (req_data.operation == OP_TICK && running_ff) begin
            unique case (seg_ff)
               ST_TONE_A: begin
                  push_data.tone     = 1'b1;
                  push_data.phase_hi = phase_a_ff[31:16];
                  phase_a_in         = phase_a_ff + cfg.tone_a_step;
                  if (next_count >= {1'b0, cfg.tone_samples}) begin
                     count_in = '0;
                     seg_in   = ST_TONE_B;
                  end else begin
                     count_in = next_count[15:0];
                  end
               end
               ST_TONE_B: begin
                  push_data.tone     = 1'b1;
                  push_data.phase_hi = phase_b_ff[31:16];
                  phase_b_in         = phase_b_ff + cfg.tone_b_step;
                  if (next_count >= {1'b0, cfg.tone_samples}) begin
                     count_in = '0;
                     if (cfg.gap_samples == 16'd0) begin
                        // no gap: cycle ends after last tone B sample
                        elapsed_in = elapsed_next;
                        if (elapsed_next < limit_ff) begin
                           seg_in = ST_TONE_A;
                        end else begin
                           seg_in     = ST_IDLE;
                           running_in = 1'b0;
                        end
                     end else begin
                        seg_in = ST_GAP;
                     end
                  end else begin
                     count_in = next_count[15:0];
                  end
               end
               ST_GAP: begin
                  if (next_count >= {1'b0, cfg.gap_samples}) begin
                     count_in   = '0;
                     elapsed_in = elapsed_next;
                     if (elapsed_next < limit_ff) begin
                        seg_in = ST_TONE_A;
                     end else begin
                        seg_in     = ST_IDLE;
                        running_in = 1'b0;
                     end
                  end else begin
                     count_in = next_count[15:0];
                  end
               end
               default: begin
                  running_in       = 1'b0;
                  push_data.active = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_a_ff <= '0;
         phase_b_ff <= '0;
         seg_ff     <= ST_IDLE;
         count_ff   <= '0;
         elapsed_ff <= '0;
         limit_ff   <= LIMIT_RESET;
         running_ff <= 1'b0;
      end else begin
         phase_a_ff <= phase_a_in;
         phase_b_ff <= phase_b_in;
         seg_ff     <= seg_in;
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
         limit_ff   <= limit_in;
         running_ff <= running_in;
      end
   end

endmodule

>>> src/ttag_queue.sv
// Short FIFO of classified work between the front and back ends.
// Depends on ttag_pkg.
module ttag_queue
   import ttag_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  work_type push_data,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_data
);

   work_type            q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = q_mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/ttag_back.sv
// Back end: quarter-wave sine lookup, amplitude scaling and result register.
// Depends on ttag_pkg; pulls work from ttag_queue.
module ttag_back
   import ttag_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [14:0] amplitude,
   input  logic        pop_valid,
   input  work_type    pop_data,
   output logic        pop_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int TABLE_LEN = 1 << SINE_TABLE_BITS;

   logic [14:0] sine_rom [TABLE_LEN];

   for (genvar k = 0; k < TABLE_LEN; k++) begin : g_rom
      localparam logic [14:0] ENTRY = sine_entry(k, SINE_TABLE_BITS);
      assign sine_rom[k] = ENTRY;
   end

   logic [1:0]                 quad;
   logic [SINE_TABLE_BITS-1:0] raw_idx;
   logic [SINE_TABLE_BITS-1:0] rom_idx;

   // stage 1: table read
   logic        s1_valid_ff;
   logic [14:0] s1_entry_ff;
   logic        s1_neg_ff;
   logic        s1_tone_ff;
   logic        s1_active_ff;
   logic [1:0]  s1_seg_ff;

   // stage 2: result register
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;

   logic        s1_take;
   logic        s2_take;
   logic [29:0] product;
   logic [15:0] magnitude;

   assign quad    = pop_data.phase_hi[15:14];
   assign raw_idx = pop_data.phase_hi[13 -: SINE_TABLE_BITS];
   // quadrants 1 and 3 run the table backward
   assign rom_idx = quad[0] ? ~raw_idx : raw_idx;

   assign s2_take   = !rsp_valid_ff || !rsp_stall;
   assign s1_take   = !s1_valid_ff || s2_take;
   assign pop_ready = s1_take;

   assign product   = 30'(s1_entry_ff) * 30'(amplitude);
   assign magnitude = {1'b0, product[29:15]};

   always_comb begin
      rsp_data_in.active  = s1_active_ff;
      rsp_data_in.segment = s1_seg_ff;
      if (!s1_tone_ff) begin
         rsp_data_in.sample = '0;
      end else if (s1_neg_ff) begin
         rsp_data_in.sample = -$signed(magnitude);
      end else begin
         rsp_data_in.sample = $signed(magnitude);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            s1_valid_ff <= pop_valid;
         end
         if (s2_take) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take && pop_valid) begin
         s1_entry_ff  <= sine_rom[rom_idx];
         s1_neg_ff    <= quad[1];
         s1_tone_ff   <= pop_data.tone;
         s1_active_ff <= pop_data.active;
         s1_seg_ff    <= pop_data.segment;
      end
      if (s2_take && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/ttag_checker.sv
// Port-level checks for the two-tone alarm generator, bound to the top level.
// Depends on ttag_pkg and two_tone_alarm_generator_top_assert.svh.
`include "two_tone_alarm_generator_top_assert.svh"

module ttag_checker
   import ttag_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input req_type                req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_type                rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [31:0]            csr_wdata
);

   // a stalled result transaction holds
   `TTAG_ASSERT_NXT(a_rsp_hold, clock, reset, !reset && rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp changed under stall")

   // gap and idle samples are silent
   `TTAG_ASSERT_IMP(a_silent, clock, reset, rsp_valid && (rsp_data.segment == SEG_GAP || rsp_data.segment == SEG_IDLE), rsp_data.sample == 16'sd0, "nonzero sample in gap or idle")

   // inactive results always report the idle segment
   `TTAG_ASSERT_IMP(a_idle_seg, clock, reset, rsp_valid && !rsp_data.active, rsp_data.segment == SEG_IDLE, "inactive result outside idle segment")

   // scaled sine never reaches full negative scale
   `TTAG_ASSERT_IMP(a_range, clock, reset, rsp_valid, rsp_data.sample != 16'sh8000, "sample out of range")

endmodule

bind two_tone_alarm_generator_top ttag_checker u_ttag_checker (.*);
